// ===== hw/rtl/mnc_pkg.sv =====
// shared constants, register codes and the neighbour count function
package mnc_pkg;

	localparam int MNC_MAX_COLS = 32;
	localparam int MNC_MAX_ROWS = 1024;

	localparam logic [10:0] MNC_ROW_COUNT_RST = 11'd8;
	localparam logic [5:0]  MNC_COL_COUNT_RST = 6'd8;

	// configuration register indexes
	localparam logic REG_ROW_COUNT = 1'b0;
	localparam logic REG_COL_COUNT = 1'b1;

	// result slots of one item: upper row before lower, left before right
	localparam logic [1:0] SLOT_UL = 2'd0;
	localparam logic [1:0] SLOT_UR = 2'd1;
	localparam logic [1:0] SLOT_LL = 2'd2;
	localparam logic [1:0] SLOT_LR = 2'd3;

	// mines around window cell (q0, k0), only over rows and columns inside the grid
	function automatic logic [3:0] nb_count(
		input logic [8:0] win,
		input logic [1:0] q0,
		input logic [1:0] k0,
		input logic [2:0] row_ok,
		input logic [2:0] col_ok
	);
		logic [3:0] total;
		total = 4'd0;
		for (int q = 0; q < 3; q++) begin
			for (int k = 0; k < 3; k++) begin
				if (q + 1 >= int'(q0) && q <= int'(q0) + 1 &&
				    k + 1 >= int'(k0) && k <= int'(k0) + 1 &&
				    row_ok[q] && col_ok[k] &&
				    !(q == int'(q0) && k == int'(k0))) begin
					total = total + {3'b000, win[3 * q + k]};
				end
			end
		end
		return total;
	endfunction

endpackage

// ===== hw/rtl/mine_neighbor_count.sv =====
// minesweeper neighbour counter over a raster stream of mine bits
//
// Cells enter in raster order, one per clock, over a grid of row_count rows and
// col_count columns (register 0 and register 1; 0 reads as 1, too large reads as
// the maximum). Every cell gives one result, its mine flag and, for a clear cell,
// the number of mines among its in-grid neighbours. A result leaves as soon as
// all its neighbours have arrived, about one row plus one cell after the cell
// itself. Most cells give at most one result, so the block sustains one cell per
// clock unless stalled; the last cell of each row but the first and every cell of
// the last row past its first column give two results and the final cell of the
// grid up to four; as the output register drains one result per clock, such a
// cell stalls the input while its results drain. Per column, the two most recent
// rows sit in a small synchronous memory read when the cell is taken and written
// back when the cell moves on to the output register; a back-to-back access to
// the same column is forwarded. No clearing pass is needed after reset.
module mine_neighbor_count import mnc_pkg::*; #(
	parameter int MAX_COLS = MNC_MAX_COLS,
	parameter int MAX_ROWS = MNC_MAX_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cell_valid,
	output logic        cell_stall,
	input  logic        cell_is_mine,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        out_is_mine,
	output logic [3:0]  mine_count,
	output logic        last_in_run,
	output logic        end_of_grid,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int SlotW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RowCap = (MAX_ROWS < 2047) ? MAX_ROWS : 2047;
	localparam int ColCap = (MAX_COLS < 63) ? MAX_COLS : 63;

	typedef struct packed {
		logic bit_in;
		logic r_ge1;
		logic r_ge2;
		logic c_ge1;
		logic c_ge2;
		logic last_row;
		logic last_col;
	} pos_t;

	logic [10:0] row_count_q;
	logic [5:0]  col_count_q;
	logic [10:0] row_idx_q;
	logic [5:0]  col_idx_q;
	logic [8:0]  win_q;

	logic [1:0]          row_mem [MAX_COLS];
	logic [MAX_COLS-1:0] row_vld_q;

	logic             s1_valid_q;
	pos_t             pos_s1;
	logic [SlotW-1:0] slot_s1;
	logic [1:0]       rd_s1;
	logic             vld_s1;
	logic             fwd_s1;
	logic [1:0]       fwd_data_s1;

	logic [3:0]       pend_s2;
	logic [3:0]       mine_s2;
	logic [3:0]       cnt_s2 [4];

	logic [10:0]      rows_eff;
	logic [5:0]       cols_eff;
	logic             last_row;
	logic             last_col;
	logic [SlotW-1:0] slot_in;
	logic             cell_take;
	logic             result_take;
	logic             s2_free;
	logic             retire;
	logic [1:0]       stored;
	logic [1:0]       wdata;
	logic [8:0]       win_next;
	logic [2:0]       row_ok;
	logic [2:0]       col_ok;
	logic [3:0]       mask_next;
	logic [3:0]       cnt_next [4];
	logic [3:0]       mine_next;
	logic [1:0]       sel;
	logic             hit;

	// effective grid size and position of the incoming cell
	always_comb begin
		if (row_count_q == 11'd0) begin
			rows_eff = 11'd1;
		end else if (row_count_q > 11'(RowCap)) begin
			rows_eff = 11'(RowCap);
		end else begin
			rows_eff = row_count_q;
		end
		if (col_count_q == 6'd0) begin
			cols_eff = 6'd1;
		end else if (col_count_q > 6'(ColCap)) begin
			cols_eff = 6'(ColCap);
		end else begin
			cols_eff = col_count_q;
		end
	end

	assign last_row = ({1'b0, row_idx_q} + 12'd1) >= {1'b0, rows_eff};
	assign last_col = ({1'b0, col_idx_q} + 7'd1) >= {1'b0, cols_eff};
	assign slot_in  = (col_idx_q >= 6'(MAX_COLS)) ? SlotW'(MAX_COLS - 1)
	                                              : col_idx_q[SlotW-1:0];

	// handshakes
	assign result_valid = |pend_s2;
	assign result_take  = result_valid && !result_stall;
	assign s2_free      = !result_valid || (result_take && last_in_run);
	assign retire       = s1_valid_q && s2_free;
	assign cell_stall   = s1_valid_q && !s2_free;
	assign cell_take    = cell_valid && !cell_stall;
	assign cfg_ready    = 1'b1;

	// read-modify-write of the line store and window update
	assign stored   = fwd_s1 ? fwd_data_s1 : (vld_s1 ? rd_s1 : 2'b00);
	assign wdata    = {pos_s1.bit_in, stored[1]};
	assign win_next = ((win_q >> 1) & 9'h0DB) | {6'b000000, stored[0], 2'b00}
	                | {3'b000, stored[1], 5'b00000} | {pos_s1.bit_in, 8'h00};
	assign hit      = retire && (slot_s1 == slot_in);

	assign row_ok = {1'b1, pos_s1.r_ge1, pos_s1.r_ge2};
	assign col_ok = {1'b1, pos_s1.c_ge1, pos_s1.c_ge2};

	always_comb begin
		mask_next[SLOT_UL] = pos_s1.r_ge1 && pos_s1.c_ge1;
		mask_next[SLOT_UR] = pos_s1.r_ge1 && pos_s1.last_col;
		mask_next[SLOT_LL] = pos_s1.last_row && pos_s1.c_ge1;
		mask_next[SLOT_LR] = pos_s1.last_row && pos_s1.last_col;
		mine_next[SLOT_UL] = win_next[4];
		mine_next[SLOT_UR] = win_next[5];
		mine_next[SLOT_LL] = win_next[7];
		mine_next[SLOT_LR] = win_next[8];
		cnt_next[SLOT_UL]  = nb_count(win_next, 2'd1, 2'd1, row_ok, col_ok);
		cnt_next[SLOT_UR]  = nb_count(win_next, 2'd1, 2'd2, row_ok, col_ok);
		cnt_next[SLOT_LL]  = nb_count(win_next, 2'd2, 2'd1, row_ok, col_ok);
		cnt_next[SLOT_LR]  = nb_count(win_next, 2'd2, 2'd2, row_ok, col_ok);
	end

	// output selection: lowest pending slot first
	always_comb begin
		if (pend_s2[SLOT_UL]) begin
			sel = SLOT_UL;
		end else if (pend_s2[SLOT_UR]) begin
			sel = SLOT_UR;
		end else if (pend_s2[SLOT_LL]) begin
			sel = SLOT_LL;
		end else begin
			sel = SLOT_LR;
		end
	end

	assign out_is_mine = mine_s2[sel];
	assign mine_count  = mine_s2[sel] ? 4'd0 : cnt_s2[sel];
	assign last_in_run = (pend_s2 & (pend_s2 - 4'd1)) == 4'd0;
	assign end_of_grid = (sel == SLOT_LR);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= MNC_ROW_COUNT_RST;
			col_count_q <= MNC_COL_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data;
				REG_COL_COUNT: col_count_q <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_idx_q <= 11'd0;
			col_idx_q <= 6'd0;
		end else if (cell_take) begin
			if (last_col) begin
				col_idx_q <= 6'd0;
				row_idx_q <= last_row ? 11'd0 : row_idx_q + 11'd1;
			end else begin
				col_idx_q <= col_idx_q + 6'd1;
			end
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (retire) begin
			row_mem[slot_s1] <= wdata;
		end
		if (cell_take) begin
			rd_s1 <= row_mem[slot_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			win_q     <= 9'd0;
		end else if (retire) begin
			row_vld_q[slot_s1] <= 1'b1;
			win_q              <= win_next;
		end
	end

	// stage 1: cell waiting for its line store data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (cell_take) begin
			s1_valid_q <= 1'b1;
		end else if (retire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_take) begin
			pos_s1.bit_in   <= cell_is_mine;
			pos_s1.r_ge1    <= row_idx_q >= 11'd1;
			pos_s1.r_ge2    <= row_idx_q >= 11'd2;
			pos_s1.c_ge1    <= col_idx_q >= 6'd1;
			pos_s1.c_ge2    <= col_idx_q >= 6'd2;
			pos_s1.last_row <= last_row;
			pos_s1.last_col <= last_col;
			slot_s1         <= slot_in;
			vld_s1          <= row_vld_q[slot_in];
			fwd_s1          <= hit;
			fwd_data_s1     <= wdata;
		end
	end

	// stage 2: results of one cell, drained one per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= 4'd0;
		end else if (retire) begin
			pend_s2 <= mask_next;
		end else if (result_take) begin
			pend_s2 <= pend_s2 & ~(4'd1 << sel);
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			mine_s2 <= mine_next;
			cnt_s2  <= cnt_next;
		end
	end

	// checks
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && end_of_grid |-> last_in_run)
		else $error("end of grid result not last of its run");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> mine_count <= 4'd8)
		else $error("neighbour count above eight");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !retire |=> s1_valid_q)
		else $error("stage 1 cell lost while stalled");

	a_no_take_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && result_valid && !last_in_run |-> !cell_take)
		else $error("cell taken while results still pending");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for mine_neighbor_count with a neighbour count predictor
`timescale 1ns / 100ps

module testbench;
	import mnc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic       is_mine;
		logic [3:0] count;
		logic       run_end;
		logic       grid_end;
	} cell_result_t;

	logic        clk;
	logic        arst_n;
	logic        cell_valid;
	logic        cell_stall;
	logic        cell_is_mine;
	logic        result_valid;
	logic        result_stall;
	logic        out_is_mine;
	logic [3:0]  mine_count;
	logic        last_in_run;
	logic        end_of_grid;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [10:0] cfg_data;

	// predictor state
	logic [1:0]  col_history [MNC_MAX_COLS];
	logic [8:0]  nbr_window;
	logic [5:0]  col_pos;
	logic [10:0] row_pos;
	logic [10:0] rows_reg;
	logic [5:0]  cols_reg;

	cell_result_t awaited_cells[$];
	cell_result_t next_want;

	int mismatches;
	int cycle_count;
	int stall_left;
	int hold_request;
	bit tx_idle_on;
	bit rx_idle_on;

	mine_neighbor_count dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cell_valid   (cell_valid),
		.cell_stall   (cell_stall),
		.cell_is_mine (cell_is_mine),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_is_mine  (out_is_mine),
		.mine_count   (mine_count),
		.last_in_run  (last_in_run),
		.end_of_grid  (end_of_grid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int clamp_size(input int v, input int hi);
		if (v < 1)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// mines around window cell (q0, k0), rows and columns before the grid start masked off
	function automatic logic [3:0] mines_around(input int q0, input int k0, input int r,
		input int c);
		logic [3:0] total;
		total = 4'd0;
		for (int q = 0; q < 3; q++) begin
			if (q + 1 < q0 || q > q0 + 1 || r + q < 2)
				continue;
			for (int k = 0; k < 3; k++) begin
				if (k + 1 < k0 || k > k0 + 1 || c + k < 2 || (q == q0 && k == k0))
					continue;
				total = total + 4'(nbr_window[3 * q + k]);
			end
		end
		return total;
	endfunction

	function automatic void scan_cell(input logic mine);
		int rows;
		int cols;
		int r;
		int c;
		int slot;
		int nq;
		int nk;
		int qs [2];
		int ks [2];
		bit last_col;
		bit last_row;
		logic [1:0] old;
		cell_result_t res;
		rows = clamp_size(int'(rows_reg), MNC_MAX_ROWS);
		cols = clamp_size(int'(cols_reg), MNC_MAX_COLS);
		r = int'(row_pos);
		c = int'(col_pos);
		last_col = (c + 1 >= cols);
		last_row = (r + 1 >= rows);
		slot = (c < MNC_MAX_COLS) ? c : MNC_MAX_COLS - 1;
		old = col_history[slot];
		col_history[slot] = {mine, old[1]};
		nbr_window = ((nbr_window >> 1) & 9'h0DB) | (9'(old[0]) << 2) | (9'(old[1]) << 5)
			| (9'(mine) << 8);
		nq = 0;
		nk = 0;
		if (r >= 1) begin
			qs[nq] = 1;
			nq++;
		end
		if (last_row) begin
			qs[nq] = 2;
			nq++;
		end
		if (c >= 1) begin
			ks[nk] = 1;
			nk++;
		end
		if (last_col) begin
			ks[nk] = 2;
			nk++;
		end
		for (int i = 0; i < nq; i++) begin
			for (int j = 0; j < nk; j++) begin
				res.is_mine = nbr_window[3 * qs[i] + ks[j]];
				res.count = res.is_mine ? 4'd0 : mines_around(qs[i], ks[j], r, c);
				res.run_end = (i == nq - 1) && (j == nk - 1);
				res.grid_end = last_row && last_col && qs[i] == 2 && ks[j] == 2;
				awaited_cells.insert(awaited_cells.size(), res);
			end
		end
		if (last_col) begin
			col_pos = 6'd0;
			row_pos = last_row ? 11'd0 : 11'(r + 1);
		end else begin
			col_pos = 6'(c + 1);
		end
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch: %s got %0d want %0d at cycle %0d", what, got, want,
				cycle_count);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_cells.size() == 0) begin
				flag_mismatch("result with none awaited", 1, 0);
			end else begin
				next_want = awaited_cells.pop_front();
				if (out_is_mine !== next_want.is_mine)
					flag_mismatch("out_is_mine", out_is_mine, next_want.is_mine);
				if (mine_count !== next_want.count)
					flag_mismatch("mine_count", mine_count, next_want.count);
				if (last_in_run !== next_want.run_end)
					flag_mismatch("last_in_run", last_in_run, next_want.run_end);
				if (end_of_grid !== next_want.grid_end)
					flag_mismatch("end_of_grid", end_of_grid, next_want.grid_end);
			end
		end
	end

	// result side stall: random bursts plus long holds on request
	always @(negedge clk) begin
		if (hold_request != 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left != 0) begin
			result_stall = 1'b1;
			stall_left--;
		end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
			result_stall = 1'b1;
			stall_left = $urandom_range(0, 8);
		end else begin
			result_stall = 1'b0;
		end
	end

	task automatic send_cell(input logic mine);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			cell_valid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		cell_valid = 1'b1;
		cell_is_mine = mine;
		@(posedge clk);
		while (cell_stall)
			@(posedge clk);
		scan_cell(mine);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [10:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_ROW_COUNT)
			rows_reg = data;
		else
			cols_reg = data[5:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain_results();
		cell_valid = 1'b0;
		while (awaited_cells.size() != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic set_grid(input logic [10:0] rows, input logic [10:0] cols);
		drain_results();
		write_reg(REG_ROW_COUNT, rows);
		write_reg(REG_COL_COUNT, cols);
	endtask

	// reset size is 8 x 8; stop part way into the second row
	task automatic test_reset_size();
		for (int i = 0; i < 10; i++)
			send_cell(i % 3 == 0);
	endtask

	// zero sizes read as a single cell, applied mid-grid first
	task automatic test_one_cell();
		set_grid(11'd0, 11'd0);
		send_cell(1'b1);
		send_cell(1'b0);
		send_cell(1'b0);
	endtask

	// clear centre surrounded by mines gives the top count
	task automatic test_full_surround();
		set_grid(11'd3, 11'd3);
		for (int i = 0; i < 9; i++)
			send_cell(i != 4);
	endtask

	// column write with upper data bits set, only the low six bits count
	task automatic test_single_row();
		set_grid(11'd1, 11'h7C3);
		send_cell(1'b0);
		send_cell(1'b1);
		send_cell(1'b0);
	endtask

	task automatic test_random_grids();
		int rows;
		int cols;
		int cells;
		int pct;
		int sent;
		sent = 0;
		while (sent < 200) begin
			case ($urandom_range(0, 9))
				0: begin
					rows = 2047;
					cols = 1;
				end
				1: begin
					rows = $urandom_range(1, 2);
					cols = ($urandom_range(0, 1) != 0) ? 32 : 63;
				end
				2: begin
					rows = 1;
					cols = $urandom_range(1, 20);
				end
				3: begin
					rows = $urandom_range(1, 6);
					cols = 1;
				end
				default: begin
					rows = $urandom_range(1, 5);
					cols = $urandom_range(2, 10);
				end
			endcase
			set_grid(11'(rows), 11'(cols));
			cells = clamp_size(rows, MNC_MAX_ROWS) * clamp_size(cols, MNC_MAX_COLS);
			if (cells > 64)
				cells = 24;
			if ($urandom_range(0, 7) == 0)
				cells = $urandom_range(1, cells);
			tx_idle_on = ($urandom_range(0, 2) != 0);
			rx_idle_on = ($urandom_range(0, 2) != 0);
			pct = $urandom_range(0, 4) * 25;
			for (int i = 0; i < cells; i++)
				send_cell($urandom_range(0, 99) < pct);
			sent += cells;
		end
	endtask

	// receiver holds off while cells keep coming, so the block backs up
	task automatic test_backpressure();
		set_grid(11'd4, 11'd8);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		hold_request = 150;
		for (int i = 0; i < 32; i++)
			send_cell(1'($urandom_range(0, 1)));
	endtask

	// sender pauses mid-grid until every awaited result is in
	task automatic test_pause_midgrid();
		set_grid(11'd3, 11'd5);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		for (int i = 0; i < 7; i++)
			send_cell(1'($urandom_range(0, 1)));
		drain_results();
		for (int i = 0; i < 8; i++)
			send_cell(1'($urandom_range(0, 1)));
	endtask

	task automatic test_full_rate();
		set_grid(11'd5, 11'd8);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		for (int i = 0; i < 40; i++)
			send_cell(1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		cell_valid = 1'b0;
		cell_is_mine = 1'b0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROW_COUNT;
		cfg_data = 11'd0;
		mismatches = 0;
		cycle_count = 0;
		stall_left = 0;
		hold_request = 0;
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rows_reg = MNC_ROW_COUNT_RST;
		cols_reg = MNC_COL_COUNT_RST;
		nbr_window = 9'd0;
		col_pos = 6'd0;
		row_pos = 11'd0;
		for (int i = 0; i < MNC_MAX_COLS; i++)
			col_history[i] = 2'b00;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_reset_size();
		test_one_cell();
		test_full_surround();
		test_single_row();
		test_random_grids();
		test_backpressure();
		test_pause_midgrid();
		test_full_rate();
		drain_results();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== mine_neighbor_count.f =====
hw/rtl/mnc_pkg.sv
hw/rtl/mine_neighbor_count.sv
tb/testbench.sv
